// File: sv/fdf_pkg.sv
package fdf_pkg;

    // Built size and number formats
    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;

    // Fixed field widths of the channels and registers
    localparam int COEF_IDX_W = 6;
    localparam int DECIM_W    = 5;
    localparam int TAPS_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int MAX_DECIM  = 16;

    // Derived widths
    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_CW = $clog2(MAX_TAPS + 1);
    localparam int STEP_W = $clog2(MAX_TAPS + 2);
    localparam int PHASE_W = 4;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + TAP_AW;
    localparam int Q_W    = ACC_W + 2 - COEF_BITS;

    // Last step of a run: the taps plus the multiply/accumulate drain
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_TAPS + 1);

    // Output range
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 1'd1;

    // Word kinds on the input channel
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_fdf_state;

    // Control of one delay cell
    typedef struct packed {
        logic shift;
        logic rotate;
    } t_fdf_cell_ctl;

    // One term handed to the MAC
    typedef struct packed {
        logic                          vld;
        logic signed [SAMPLE_BITS-1:0] x;
    } t_fdf_term;

    // Rounded, saturated result
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          sat;
    } t_fdf_result;

endpackage

// File: sv/fdf_in_if.sv
interface fdf_in_if;
    import fdf_pkg::*;

    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic        [COEF_IDX_W-1:0]       coef_index;
    logic signed [COEF_BITS-1:0]        coef_value;
    logic signed [SAMPLE_BITS-1:0]      sample_value;
    logic                               block_start;

    modport source (
        output valid, kind, coef_index, coef_value, sample_value, block_start,
        input  ready
    );

    modport sink (
        input  valid, kind, coef_index, coef_value, sample_value, block_start,
        output ready
    );

endinterface

// File: sv/fdf_out_if.sv
interface fdf_out_if;
    import fdf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered_value;
    logic                          saturated;

    modport source (
        output valid, filtered_value, saturated,
        input  ready
    );

    modport sink (
        input  valid, filtered_value, saturated,
        output ready
    );

endinterface

// File: sv/fdf_ram.sv
module fdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/fdf_tap_cell.sv
module fdf_tap_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fdf_pkg::t_fdf_cell_ctl                 i_ctl,
    input  logic signed [fdf_pkg::SAMPLE_BITS-1:0] i_from_prev,
    input  logic signed [fdf_pkg::SAMPLE_BITS-1:0] i_from_next,
    output logic signed [fdf_pkg::SAMPLE_BITS-1:0] o_sample
);
    import fdf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_sample;

    // Shift toward older positions on a new sample, rotate toward the head during a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctl.shift) begin
            r_sample <= i_from_prev;
        end else if (i_ctl.rotate) begin
            r_sample <= i_from_next;
        end
    end

    assign o_sample = r_sample;

endmodule

// File: sv/fdf_mac.sv
module fdf_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clr,
    input  fdf_pkg::t_fdf_term                   i_term,
    input  logic signed [fdf_pkg::COEF_BITS-1:0] i_coef,
    output fdf_pkg::t_fdf_result                 o_res
);
    import fdf_pkg::*;

    logic                          r_vld1;
    logic                          r_vld2;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic signed [ACC_W:0]         w_biased;
    logic signed [Q_W-1:0]         w_q;

    // Term valid pipeline; the coefficient arrives in the cycle after the sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_term.vld;
            r_vld2 <= r_vld1;
        end
    end

    // Sample capture, product, accumulate
    always_ff @(posedge i_clk) begin
        r_x    <= i_term.x;
        r_prod <= PROD_W'(r_x * i_coef);
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_vld2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, then clip to the sample range
    assign w_biased = (ACC_W+1)'(r_acc) + (ACC_W+1)'(1 << (COEF_BITS - 2));
    assign w_q      = Q_W'(w_biased >>> (COEF_BITS - 1));

    always_comb begin
        o_res.value = w_q[SAMPLE_BITS-1:0];
        o_res.sat   = 1'b0;
        if (w_q > Q_W'(SAT_MAX)) begin
            o_res.value = SAT_MAX;
            o_res.sat   = 1'b1;
        end else if (w_q < Q_W'(SAT_MIN)) begin
            o_res.value = SAT_MIN;
            o_res.sat   = 1'b1;
        end
    end

endmodule

// File: sv/fir_decimating_filter_unit.sv
// Decimating FIR filter.
// Input channel i_in_ch (valid/ready): each word either writes one Q1.15
// coefficient (kind = 0) or brings one signed sample (kind = 1). Output
// channel o_out_ch (valid/ready) carries a rounded, saturated result with a
// clip flag. Registers decimation_factor (index 0) and taps_in_use (index 1)
// are written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must write
// them only while idle, and the block itself does not enforce this.
// Samples live in a ring of tap cells. When a sample word completes a window
// (first full window of a block, then every decimation factor samples) the
// ring rotates once through all MAX_TAPS cells while a single multiplier
// works through the taps in the run state; the done state then loads the
// output register, and no word is accepted until the block is idle again.
// Coefficient words and other sample words leave the block idle.
// Reset clears the delay line, fill count, phase and output valid, and sets the
// registers to decimation 1 and all taps; coefficients must be written first.
// If the receiver stalls, the result waits in the output register; a following
// result waits in the block until it is taken, and no input is accepted then.
module fir_decimating_filter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fdf_in_if.sink                           i_in_ch,
    fdf_out_if.source                        o_out_ch,
    input  logic                             i_cfg_we,
    input  logic [fdf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import fdf_pkg::*;

    t_fdf_state r_state, n_state;

    logic [DECIM_W-1:0]  r_decim;
    logic [TAPS_W-1:0]   r_taps;
    logic [TAP_CW-1:0]   r_fill, n_fill;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [TAP_CW-1:0]   r_run_taps, n_run_taps;

    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_sat;

    logic in_ready;
    logic in_acc;
    logic shift;
    logic mac_clr;
    logic load_out;

    logic [TAP_CW-1:0]   t_eff;
    logic [DECIM_W-1:0]  d_eff;
    logic [TAP_CW-1:0]   fc;
    logic [PHASE_W-1:0]  ph;
    logic [PHASE_W:0]    ph_inc;
    logic                was_full;
    logic [TAP_CW-1:0]   fill_nxt;
    logic [PHASE_W-1:0]  phase_nxt;
    logic                go;

    logic                coef_we;
    logic [TAP_AW-1:0]   coef_raddr;
    logic [COEF_BITS-1:0] coef_rdata;

    t_fdf_cell_ctl                 cell_ctl;
    logic signed [SAMPLE_BITS-1:0] w_cell [MAX_TAPS];
    t_fdf_term                     term;
    t_fdf_result                   res;

    assign in_ready       = (r_state == ST_IDLE);
    assign i_in_ch.ready  = in_ready;
    assign in_acc         = i_in_ch.valid && in_ready;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= DECIM_W'(1);
            r_taps  <= TAPS_W'(MAX_TAPS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DECIM: r_decim <= i_cfg_wdata[DECIM_W-1:0];
                CFG_TAPS:  r_taps  <= i_cfg_wdata[TAPS_W-1:0];
                default:   ;
            endcase
        end
    end

    // Effective taps and decimation, clamped to their ranges
    always_comb begin
        if (r_taps == '0) begin
            t_eff = TAP_CW'(1);
        end else if (32'(r_taps) > 32'(MAX_TAPS)) begin
            t_eff = TAP_CW'(MAX_TAPS);
        end else begin
            t_eff = TAP_CW'(r_taps);
        end
        if (r_decim == '0) begin
            d_eff = DECIM_W'(1);
        end else if (32'(r_decim) > 32'(MAX_DECIM)) begin
            d_eff = DECIM_W'(MAX_DECIM);
        end else begin
            d_eff = r_decim;
        end
    end

    // Window fill and decimation phase for an incoming sample
    always_comb begin
        fc        = i_in_ch.block_start ? '0 : r_fill;
        ph        = i_in_ch.block_start ? '0 : r_phase;
        was_full  = (fc >= t_eff);
        fill_nxt  = (32'(fc) < 32'(MAX_TAPS)) ? fc + 1'b1 : fc;
        ph_inc    = {1'b0, ph} + 1'b1;
        go        = 1'b0;
        phase_nxt = ph;
        if (!was_full) begin
            if (fill_nxt >= t_eff) begin
                go        = 1'b1;
                phase_nxt = '0;
            end
        end else if (32'(ph_inc) >= 32'(d_eff)) begin
            go        = 1'b1;
            phase_nxt = '0;
        end else begin
            phase_nxt = ph_inc[PHASE_W-1:0];
        end
    end

    // Sequencer: next state and controls
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_phase    = r_phase;
        n_step     = r_step;
        n_run_taps = r_run_taps;
        shift      = 1'b0;
        mac_clr    = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_ch.kind == KIND_SAMPLE)) begin
                    shift   = 1'b1;
                    n_fill  = fill_nxt;
                    n_phase = phase_nxt;
                    if (go) begin
                        n_state    = ST_RUN;
                        n_step     = '0;
                        n_run_taps = t_eff;
                        mac_clr    = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || o_out_ch.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_phase <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_taps <= n_run_taps;
    end

    // Coefficient store
    assign coef_we    = in_acc && (i_in_ch.kind == KIND_COEF) &&
                        (32'(i_in_ch.coef_index) < 32'(MAX_TAPS));
    assign coef_raddr = TAP_AW'(32'(r_run_taps) - 32'd1 - 32'(r_step));

    fdf_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (TAP_AW'(i_in_ch.coef_index)),
        .i_wdata (i_in_ch.coef_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    // Delay line: ring of tap cells, read at the head
    assign cell_ctl.shift  = shift;
    assign cell_ctl.rotate = (r_state == ST_RUN) && (32'(r_step) < 32'(MAX_TAPS));

    for (genvar gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_prev;
        logic signed [SAMPLE_BITS-1:0] w_next;
        if (gi == 0) begin : g_head
            assign w_prev = i_in_ch.sample_value;
        end else begin : g_body
            assign w_prev = w_cell[gi-1];
        end
        if (gi == MAX_TAPS - 1) begin : g_tail
            assign w_next = w_cell[0];
        end else begin : g_link
            assign w_next = w_cell[gi+1];
        end
        fdf_tap_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_from_prev (w_prev),
            .i_from_next (w_next),
            .o_sample    (w_cell[gi])
        );
    end

    // Head cell at step k holds the k-th newest sample; pairs with coef[t-1-k]
    assign term.vld = (r_state == ST_RUN) && (32'(r_step) < 32'(r_run_taps));
    assign term.x   = w_cell[0];

    fdf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mac_clr),
        .i_term  (term),
        .i_coef  (coef_rdata),
        .o_res   (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= res.value;
            r_out_sat   <= res.sat;
        end
    end

    assign o_out_ch.valid          = r_out_vld;
    assign o_out_ch.filtered_value = r_out_value;
    assign o_out_ch.saturated      = r_out_sat;

    // A new result is loaded only at the end of a run
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_state == ST_DONE))
        else $error("result loaded outside of run completion");

    // Run length is fixed
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == STEP_LAST) |=> (r_state == ST_DONE))
        else $error("run did not end after last step");

    // A producing sample starts a run with a cleared accumulator
    a_go_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_clr |=> (r_state == ST_RUN && r_step == '0))
        else $error("run not started after window completed");

    // Clip flag only with a value at the range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_sat) |-> (r_out_value == SAT_MAX || r_out_value == SAT_MIN))
        else $error("saturated flag with value inside range");

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fdf_pkg::*;

    localparam int SETTLE_CYCLES = MAX_TAPS + 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_WORDS   = 58;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    fdf_in_if  in_ch ();
    fdf_out_if out_ch ();

    fir_decimating_filter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Filter state as the testbench sees it
    logic signed [SAMPLE_BITS-1:0] dline    [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
    logic [DECIM_W-1:0]            decim_reg;
    logic [TAPS_W-1:0]             taps_reg;
    int                            fill_count;
    int                            decim_phase;

    t_fdf_result expected_outputs[$];
    int          error_count;
    bit          no_gaps;
    int          out_stall;
    int          idle_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rounded, saturated dot product over the current window
    function automatic t_fdf_result filter_output(input int t);
        t_fdf_result res;
        longint      acc;
        longint      q;
        acc = 0;
        for (int j = 0; j < t; j++)
            acc += longint'(coef_mem[j]) * longint'(dline[t-1-j]);
        q = (acc + 64'sd16384) >>> (COEF_BITS - 1);
        res.sat = 1'b0;
        if (q > longint'(SAT_MAX)) begin
            q = longint'(SAT_MAX);
            res.sat = 1'b1;
        end else if (q < longint'(SAT_MIN)) begin
            q = longint'(SAT_MIN);
            res.sat = 1'b1;
        end
        res.value = q[SAMPLE_BITS-1:0];
        return res;
    endfunction

    // Append one expected result at the tail of the queue
    function automatic void queue_result(input t_fdf_result res);
        expected_outputs = {expected_outputs, res};
    endfunction

    // Update the filter state with one accepted word, queue any result
    task automatic apply_filter_word(input logic kind, input logic [COEF_IDX_W-1:0] idx,
                                     input logic signed [COEF_BITS-1:0] cval,
                                     input logic signed [SAMPLE_BITS-1:0] sval,
                                     input logic bs);
        int t;
        int d;
        bit was_full;
        if (kind == KIND_COEF) begin
            coef_mem[idx] = cval;
            return;
        end
        if (bs) begin
            fill_count  = 0;
            decim_phase = 0;
        end
        for (int i = MAX_TAPS - 1; i > 0; i--)
            dline[i] = dline[i-1];
        dline[0] = sval;
        t = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
        d = (decim_reg == 0) ? 1 : (decim_reg > MAX_DECIM) ? MAX_DECIM : int'(decim_reg);
        was_full = (fill_count >= t);
        if (fill_count < MAX_TAPS)
            fill_count++;
        if (!was_full) begin
            if (fill_count >= t) begin
                decim_phase = 0;
                queue_result(filter_output(t));
            end
            return;
        end
        decim_phase++;
        if (decim_phase >= d) begin
            decim_phase = 0;
            queue_result(filter_output(t));
        end
    endtask

    // Send one word after a random gap; valid stays high for a back-to-back word
    task automatic send_word(input logic kind, input logic [COEF_IDX_W-1:0] idx,
                             input logic signed [COEF_BITS-1:0] cval,
                             input logic signed [SAMPLE_BITS-1:0] sval,
                             input logic bs);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.coef_index   <= idx;
        in_ch.coef_value   <= cval;
        in_ch.sample_value <= sval;
        in_ch.block_start  <= bs;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_filter_word(kind, idx, cval, sval, bs);
    endtask

    // Hold off input until every result is out and the block has settled
    task automatic drain_filter();
        in_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers while idle
    task automatic program_filter(input logic [DECIM_W-1:0] d, input logic [TAPS_W-1:0] t);
        drain_filter();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_DECIM;
        i_cfg_wdata <= CFG_DATA_W'(d);
        @(posedge i_clk);
        decim_reg   = d;
        i_cfg_idx   <= CFG_TAPS;
        i_cfg_wdata <= CFG_DATA_W'(t);
        @(posedge i_clk);
        taps_reg    = t;
        i_cfg_we    <= 1'b0;
    endtask

    // Four taps, saturation both ways, block restart, top coefficient index
    task automatic test_directed();
        program_filter(5'd1, 7'd4);
        // coefficient write ignores block_start
        send_word(KIND_COEF, 6'd0, SAT_MIN, 16'sd0, 1'b1);
        for (int i = 1; i < 4; i++)
            send_word(KIND_COEF, COEF_IDX_W'(i), SAT_MIN, 16'sd0, 1'b0);
        send_word(KIND_SAMPLE, 6'd0, 16'sd0, SAT_MIN, 1'b1);
        for (int i = 0; i < 3; i++)
            send_word(KIND_SAMPLE, 6'd0, 16'sd0, SAT_MIN, 1'b0);
        send_word(KIND_SAMPLE, 6'd0, 16'sd0, SAT_MAX, 1'b0);
        send_word(KIND_COEF, 6'd63, SAT_MAX, SAT_MIN, 1'b0);
        for (int i = 0; i < 4; i++)
            send_word(KIND_COEF, COEF_IDX_W'(i), SAT_MAX, 16'sd0, 1'b0);
        send_word(KIND_SAMPLE, 6'd0, 16'sd0, SAT_MIN, 1'b1);
        for (int i = 0; i < 3; i++)
            send_word(KIND_SAMPLE, 6'd0, 16'sd0, SAT_MIN, 1'b0);
        send_word(KIND_SAMPLE, 6'd0, 16'sd0, 16'sd0, 1'b0);
        send_word(KIND_SAMPLE, 6'd0, 16'sd0, 16'sd1, 1'b0);
        // restart: no result until four new samples
        send_word(KIND_SAMPLE, 6'd0, 16'sd0, 16'sd12345, 1'b1);
        send_word(KIND_SAMPLE, 6'd0, 16'sd0, -16'sd1, 1'b0);
    endtask

    // Fill the whole coefficient store so any tap count may be used
    task automatic test_coef_load();
        for (int i = 0; i < MAX_TAPS; i++)
            send_word(KIND_COEF, COEF_IDX_W'(i), COEF_BITS'($urandom),
                      SAMPLE_BITS'($urandom), 1'($urandom));
    endtask

    // Random streams over several register settings, extremes included
    task automatic test_random_streams();
        logic [DECIM_W-1:0]            decim_set [8];
        logic [TAPS_W-1:0]             taps_set  [8];
        logic signed [SAMPLE_BITS-1:0] sval;
        int                            pick;
        decim_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd3, 5'd1};
        taps_set  = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd64, 7'd16, 7'd33};
        decim_set[6] = DECIM_W'($urandom_range(1, MAX_DECIM));
        taps_set[7]  = TAPS_W'($urandom_range(0, 127));
        for (int p = 0; p < 8; p++) begin
            program_filter(decim_set[p], taps_set[p]);
            // one phase runs with no idling on either side
            no_gaps = (p == 4);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send_word(KIND_COEF, COEF_IDX_W'($urandom), COEF_BITS'($urandom),
                              SAMPLE_BITS'($urandom), 1'($urandom));
                end else begin
                    sval = SAMPLE_BITS'($urandom);
                    if (pick < 14)
                        sval = SAT_MIN;
                    else if (pick < 18)
                        sval = SAT_MAX;
                    send_word(KIND_SAMPLE, COEF_IDX_W'($urandom), COEF_BITS'($urandom),
                              sval, ($urandom_range(0, 49) == 0));
                end
            end
            no_gaps = 1'b0;
        end
    endtask

    // Result checker and receiver stalls
    always @(posedge i_clk) begin : result_check
        t_fdf_result exp_res;
        int          n;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall    <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result: actual value %0d saturated %0b",
                         $time, out_ch.filtered_value, out_ch.saturated);
                error_count++;
            end else begin
                exp_res = expected_outputs.pop_front();
                if (out_ch.filtered_value !== exp_res.value) begin
                    $display("%0t: filtered_value mismatch: expected %0d, actual %0d",
                             $time, exp_res.value, out_ch.filtered_value);
                    error_count++;
                end
                if (out_ch.saturated !== exp_res.sat) begin
                    $display("%0t: saturated mismatch: expected %0b, actual %0b",
                             $time, exp_res.sat, out_ch.saturated);
                    error_count++;
                end
            end
            n = no_gaps ? 0 : $urandom_range(0, 5);
            out_ch.ready <= (n == 0);
            out_stall    <= n;
        end else if (out_stall != 0) begin
            out_stall <= out_stall - 1;
            if (out_stall == 1)
                out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_DECIM;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_SAMPLE;
        in_ch.coef_index   <= '0;
        in_ch.coef_value   <= '0;
        in_ch.sample_value <= '0;
        in_ch.block_start  <= 1'b0;
        error_count = 0;
        no_gaps     = 1'b0;
        decim_reg   = 5'd1;
        taps_reg    = 7'd64;
        fill_count  = 0;
        decim_phase = 0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            dline[i]    = '0;
            coef_mem[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_coef_load();
        test_random_streams();

        drain_filter();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
sv/fdf_pkg.sv
sv/fdf_in_if.sv
sv/fdf_out_if.sv
sv/fdf_ram.sv
sv/fdf_tap_cell.sv
sv/fdf_mac.sv
sv/fir_decimating_filter_unit.sv
sim/testbench.sv
